[sv/anep_pkg.sv]
// Package for the ASCII number entry parser.
// Holds the value width, character codes, result kinds and the step result type.
// No dependencies.
package anep_pkg;

    localparam int VALUE_BITS = 32;
    localparam int OUT_BITS   = 32;
    localparam int CHAR_BITS  = 8;
    localparam int COUNT_BITS = 8;
    localparam int ADDR_BITS  = 3;

    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_BITS-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LOW_F = 8'h66;

    localparam logic KIND_ECHO  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    localparam logic [ADDR_BITS-1:0] ADDR_BASE_MODE = 3'd0;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Divide by ten as a multiply by the rounded-up reciprocal of 2^(VALUE_BITS+3)/10.
    localparam int DIV10_SHIFT = VALUE_BITS + 3;
    localparam logic [DIV10_SHIFT:0] DIV10_ONE = {1'b1, {DIV10_SHIFT{1'b0}}};
    localparam logic [DIV10_SHIFT:0] DIV10_FULL = (DIV10_ONE + (DIV10_SHIFT+1)'(9)) / 10;
    localparam logic [VALUE_BITS-1:0] DIV10_MUL = DIV10_FULL[VALUE_BITS-1:0];

    typedef struct packed {
        logic                   res_valid;
        logic                   kind;
        logic [CHAR_BITS-1:0]   echo_char;
        logic [OUT_BITS-1:0]    value;
        logic                   upd;
        logic [VALUE_BITS-1:0]  acc_next;
        logic [COUNT_BITS-1:0]  count_next;
    } step_t;

endpackage

[sv/anep_step.sv]
// Per-character update of the number entry state.
// Decodes one character and forms the next value, digit count and result word.
// Depends on anep_pkg.
module anep_step
    import anep_pkg::*;
(
    input  logic [CHAR_BITS-1:0]  char_in,
    input  logic                  hex,
    input  logic [VALUE_BITS-1:0] acc,
    input  logic [COUNT_BITS-1:0] count,
    output step_t                 step
);

    logic                       is_dec;
    logic                       is_up;
    logic                       is_low;
    logic                       is_digit;
    logic [3:0]                 digit;
    logic [VALUE_BITS-1:0]      acc_mul;
    logic [2*VALUE_BITS-1:0]    prod;
    logic [VALUE_BITS-1:0]      acc_div;
    logic [VALUE_BITS+OUT_BITS-1:0] acc_wide;

    assign is_dec   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    assign is_up    = hex && (char_in >= CH_UP_A) && (char_in <= CH_UP_F);
    assign is_low   = hex && (char_in >= CH_LOW_A) && (char_in <= CH_LOW_F);
    assign is_digit = is_dec || is_up || is_low;

    always_comb
    begin
        if (is_dec)
        begin
            digit = 4'(char_in - CH_ZERO);
        end
        else if (is_up)
        begin
            digit = 4'(char_in - CH_UP_A + 8'd10);
        end
        else
        begin
            digit = 4'(char_in - CH_LOW_A + 8'd10);
        end
    end

    assign prod    = {{VALUE_BITS{1'b0}}, acc} * {{VALUE_BITS{1'b0}}, DIV10_MUL};
    assign acc_div = VALUE_BITS'(prod >> DIV10_SHIFT);
    assign acc_mul = hex ? VALUE_BITS'({acc, digit})
                         : VALUE_BITS'((acc << 3) + (acc << 1) + VALUE_BITS'(digit));
    assign acc_wide = {{OUT_BITS{1'b0}}, acc};

    always_comb
    begin
        step.res_valid  = 1'b0;
        step.kind       = KIND_ECHO;
        step.echo_char  = char_in;
        step.value      = '0;
        step.upd        = 1'b0;
        step.acc_next   = acc;
        step.count_next = count;
        if (char_in == CH_CR)
        begin
            step.res_valid  = 1'b1;
            step.kind       = KIND_VALUE;
            step.echo_char  = '0;
            step.value      = acc_wide[OUT_BITS-1:0];
            step.upd        = 1'b1;
            step.acc_next   = '0;
            step.count_next = '0;
        end
        else if (is_digit)
        begin
            step.res_valid  = 1'b1;
            step.upd        = 1'b1;
            step.acc_next   = acc_mul;
            step.count_next = (count == COUNT_MAX) ? count : count + 1'b1;
        end
        else if ((char_in == CH_BS) && (count != '0))
        begin
            step.res_valid  = 1'b1;
            step.upd        = 1'b1;
            step.acc_next   = hex ? (acc >> 4) : acc_div;
            step.count_next = count - 1'b1;
        end
    end

endmodule

[sv/ascii_number_entry_parser.sv]
// Top level of the ASCII number entry parser.
// Holds the input stage, entry state, result register and APB mode register.
// Depends on anep_pkg and anep_step.
//
// One character is taken per clock while in_stall is low. A character waits in the
// input register. The entry update is done on the way into the result register;
// for a decimal backspace it is a multiply by the reciprocal of ten. Each result
// word is loaded into the result register as its character leaves the input stage.
// A stalled result keeps the next character in the input register. The input side
// stalls only when the input register is occupied and the result register is full
// and stalled. Digits and accepted backspaces are echoed. A carriage return
// delivers the value and clears the entry. Anything else gives no word. base_mode
// sits at address 0.
module ascii_number_entry_parser
    import anep_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CHAR_BITS-1:0]  char_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic [CHAR_BITS-1:0]  echo_char,
    output logic [OUT_BITS-1:0]   value,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic                  base_mode_reg;
    logic                  s1_valid_reg;
    logic [CHAR_BITS-1:0]  s1_char_reg;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  out_valid_reg;
    logic                  kind_reg;
    logic [CHAR_BITS-1:0]  echo_reg;
    logic [OUT_BITS-1:0]   value_reg;
    logic                  out_free;
    logic                  s1_fire;
    step_t                 step;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_BASE_MODE) ? {31'd0, base_mode_reg} : '0;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign echo_char = echo_reg;
    assign value     = value_reg;

    anep_step u_step
    (
        .char_in (s1_char_reg),
        .hex     (base_mode_reg),
        .acc     (acc_reg),
        .count   (count_reg),
        .step    (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_BASE_MODE))
        begin
            base_mode_reg <= pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_char_reg <= char_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else if (s1_fire && step.upd)
        begin
            acc_reg   <= step.acc_next;
            count_reg <= step.count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= step.res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && step.res_valid)
        begin
            kind_reg  <= step.kind;
            echo_reg  <= step.echo_char;
            value_reg <= step.value;
        end
    end

endmodule
